FILE: design/tdpp_pkg.sv
// ----------------------------------------------------------------------------
// tdpp_pkg
// Shared types and constants of the trial division prime power factorizer.
// ----------------------------------------------------------------------------
package tdpp_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;  // default width of the value used
   localparam int IN_BITS            = 32;  // width of the value field
   localparam int FP_BITS            = 32;  // width of a factor power result
   localparam int DIV_BITS           = 17;  // width of the trial divisor

   typedef struct packed {
      logic [IN_BITS-1:0] value;
   } tdpp_req_type;

   typedef struct packed {
      logic [FP_BITS-1:0] factor_power;
      logic               is_leftover;
      logic               empty_res;
      logic               last;
   } tdpp_rsp_type;

endpackage

FILE: design/tdpp_stream_if.sv
// ----------------------------------------------------------------------------
// tdpp_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tdpp_stream_if #(
   parameter type data_type = logic
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/trial_division_prime_powers.sv
// ----------------------------------------------------------------------------
// trial_division_prime_powers
// Factors an unsigned integer by trial division with 2, 3, 5, 7, 9, ... and
// streams d, d^2, ..., d^k per dividing prime d, then any leftover cofactor.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                         role
//   req_bus   in         value                                           number to factor
//   rsp_bus   out        factor_power, is_leftover, empty_res, last      one result per transfer
//
// one trial division runs on the shared shift-subtract divider (load, one
// quotient bit per cycle over NB bits, decide), NB being VALUE_BITS capped
// at the 32-bit field
// reset is synchronous and active high; it returns the sequencer to idle
// req_bus.ready is high only while idle and out of reset; a stalled result
// holds the sequencer
//
module trial_division_prime_powers
   import tdpp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   tdpp_stream_if.sink          req_bus,
   tdpp_stream_if.source        rsp_bus
);

   // value bits actually used: the input field is only IN_BITS wide
   localparam int NB    = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
   localparam int CW    = (NB > DIV_BITS) ? NB : DIV_BITS;
   localparam int CNT_W = $clog2(NB);
   localparam int PW    = NB + DIV_BITS;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LOAD     = 3'd1;  // set up the divider
   localparam logic [2:0] S_DIV      = 3'd2;  // one quotient bit per cycle
   localparam logic [2:0] S_DECIDE   = 3'd3;  // act on quotient and remainder
   localparam logic [2:0] S_WAIT_DIV = 3'd4;  // result out, then divide again
   localparam logic [2:0] S_FINISH   = 3'd5;  // flush held result, leftover
   localparam logic [2:0] S_WAIT_FIN = 3'd6;  // result out, then finish
   localparam logic [2:0] S_WAIT_END = 3'd7;  // final result out, then idle

   logic [2:0]          state_ff, state_in;
   logic [NB-1:0]       n_ff, n_in;          // running remainder of the value
   logic [DIV_BITS-1:0] d_ff, d_in;          // trial divisor
   logic [NB-1:0]       power_ff, power_in;  // next power of d to report
   logic                head_ff, head_in;    // first division with this d
   logic [NB-1:0]       quo_ff, quo_in;      // divider quotient / dividend
   logic [DIV_BITS-1:0] rem_ff, rem_in;      // divider partial remainder
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NB-1:0]       pend_ff, pend_in;    // result held until last is known
   logic                pend_valid_ff, pend_valid_in;
   tdpp_rsp_type        out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;
   logic                fits;
   logic [PW-1:0]       prod;
   logic [DIV_BITS-1:0] d_step;
   logic [NB-1:0]       value_n;
   logic                rsp_done;

   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;
   assign rsp_done      = out_valid_ff && rsp_bus.ready;

   assign value_n = req_bus.data.value[NB-1:0];

   // shift-subtract step: bring in the next dividend bit, subtract d if it fits
   assign trial = {rem_ff, quo_ff[NB-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = (trial >= {1'b0, d_ff});

   // next power of d once d has divided again
   assign prod   = PW'(power_ff) * PW'(d_ff);
   // 2 is followed by 3, then every odd number
   assign d_step = (d_ff == DIV_BITS'(2)) ? DIV_BITS'(3) : d_ff + DIV_BITS'(2);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      power_in      = power_ff;
      head_in       = head_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;

      if (rsp_done) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               n_in          = value_n;
               d_in          = DIV_BITS'(2);
               power_in      = NB'(2);
               head_in       = 1'b1;
               pend_valid_in = 1'b0;
               if (value_n <= NB'(1)) begin
                  // zero or one: a single empty result
                  out_in.factor_power = FP_BITS'(value_n);
                  out_in.is_leftover  = 1'b0;
                  out_in.empty_res    = 1'b1;
                  out_in.last         = 1'b1;
                  out_valid_in        = 1'b1;
                  state_in            = S_WAIT_END;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            quo_in   = n_ff;
            rem_in   = '0;
            cnt_in   = CNT_W'(NB - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            quo_in = {quo_ff[NB-2:0], fits};
            rem_in = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (head_ff && (CW'(d_ff) > CW'(quo_ff))) begin
               // d * d exceeds the remainder: trial division is over
               state_in = S_FINISH;
            end else if (rem_ff == '0) begin
               // d divides: record its power, keep dividing by d
               n_in          = quo_ff;
               power_in      = prod[NB-1:0];
               head_in       = 1'b0;
               pend_in       = power_ff;
               pend_valid_in = 1'b1;
               state_in      = S_LOAD;
               if (pend_valid_ff) begin
                  // an older result exists, so it is not the last one
                  out_in.factor_power = FP_BITS'(pend_ff);
                  out_in.is_leftover  = 1'b0;
                  out_in.empty_res    = 1'b0;
                  out_in.last         = 1'b0;
                  out_valid_in        = 1'b1;
                  state_in            = S_WAIT_DIV;
               end
            end else begin
               d_in     = d_step;
               power_in = NB'(d_step);
               head_in  = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_WAIT_DIV: begin
            if (rsp_done) begin
               state_in = S_LOAD;
            end
         end
         S_FINISH: begin
            out_in.empty_res = 1'b0;
            out_valid_in     = 1'b1;
            if (pend_valid_ff) begin
               out_in.factor_power = FP_BITS'(pend_ff);
               out_in.is_leftover  = 1'b0;
               pend_valid_in       = 1'b0;
               if (n_ff > NB'(1)) begin
                  out_in.last = 1'b0;
                  state_in    = S_WAIT_FIN;
               end else begin
                  out_in.last = 1'b1;
                  state_in    = S_WAIT_END;
               end
            end else begin
               // leftover cofactor above the square root
               out_in.factor_power = FP_BITS'(n_ff);
               out_in.is_leftover  = 1'b1;
               out_in.last         = 1'b1;
               state_in            = S_WAIT_END;
            end
         end
         S_WAIT_FIN: begin
            if (rsp_done) begin
               state_in = S_FINISH;
            end
         end
         S_WAIT_END: begin
            if (rsp_done) begin
               d_in     = DIV_BITS'(2);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         d_ff          <= DIV_BITS'(2);
         head_ff       <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         d_ff          <= d_in;
         head_ff       <= head_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      power_ff <= power_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   // a transfer in makes the block busy at once
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("accepted a second value while busy");

   // a result is only offered from one of the waiting states
   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (state_ff == S_WAIT_DIV || state_ff == S_WAIT_FIN ||
                         state_ff == S_WAIT_END))
      else $error("result offered outside a waiting state");

   // an empty result is always the only and final one
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.data.empty_res) |-> rsp_bus.data.last)
      else $error("empty result without last");

   // the trial divisor never drops below two
   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      d_ff >= DIV_BITS'(2))
      else $error("trial divisor below two");

   // leaving the final wait state needs the final transfer
   a_end_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT_END && !rsp_done) |=> state_ff == S_WAIT_END)
      else $error("left final wait without a transfer");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trial division prime power factorizer: a short table
// of hand-picked values, then random values built from small primes and a bounded
// cofactor, each result stream checked against the in-bench model or a typed-in answer.
// ----------------------------------------------------------------------------
module tb;

   import tdpp_pkg::*;

   // run sizing
   localparam int RANDOM_ITEMS     = 100;
   localparam int CALM_TAIL        = 20;      // last items with no idling at all
   localparam int LONG_HOLD_CYCLES = 600;     // receiver hold-off that backs up the block
   localparam int DRAIN_CYCLES     = 4 * (IN_BITS + 2);
   // the largest 32-bit prime takes by far the longest of all values run here
   localparam int CYCLE_LIMIT      = 10_000_000;
   localparam int NUM_SMALL_PRIMES = 25;
   localparam int NUM_DIRECTED     = 18;

   typedef struct {
      logic [IN_BITS-1:0] value;
      bit                 pinned;      // expected result typed in below
      tdpp_rsp_type       pinned_rsp;
   } factor_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdpp_stream_if #(.data_type(tdpp_req_type)) req_bus ();
   tdpp_stream_if #(.data_type(tdpp_rsp_type)) rsp_bus ();

   trial_division_prime_powers #(
      .VALUE_BITS(32)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   // expected prime powers in arrival order, oldest first
   tdpp_rsp_type expected_powers [$];
   // every value put on the request channel, in offer order
   factor_case_type offered_values [$];

   int error_count = 0;
   int cycle_count = 0;

   // sender-owned knobs read by the receiver process
   bit long_hold_ask = 1'b0;
   bit rsp_quiet     = 1'b0;

   int unsigned small_primes [NUM_SMALL_PRIMES] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
      53, 59, 61, 67, 71, 73, 79, 83, 89, 97
   };

   // single-result rows carry their answer, the rest go through the model
   factor_case_type directed_cases [NUM_DIRECTED] = '{
      // zero and one: no factors, flagged empty
      '{32'd0,          1'b1, tdpp_rsp_type'{32'd0, 1'b0, 1'b1, 1'b1}},
      '{32'd1,          1'b1, tdpp_rsp_type'{32'd1, 1'b0, 1'b1, 1'b1}},
      // smallest primes: loop never runs, value comes back as the cofactor
      '{32'd2,          1'b1, tdpp_rsp_type'{32'd2, 1'b1, 1'b0, 1'b1}},
      '{32'd3,          1'b1, tdpp_rsp_type'{32'd3, 1'b1, 1'b0, 1'b1}},
      '{32'd4,          1'b0, '0},
      '{32'd8,          1'b0, '0},
      '{32'd9,          1'b0, '0},
      '{32'd12,         1'b0, '0},
      '{32'd49,         1'b0, '0},
      // prime square, divisor squared equal to the remainder
      '{32'd63001,      1'b0, '0},
      // many distinct primes 2 through 23
      '{32'd223092870,  1'b0, '0},
      // 3^20, long run of powers of one prime
      '{32'd3486784401, 1'b0, '0},
      // 2^31, the most results a 32-bit value can give
      '{32'h8000_0000,  1'b0, '0},
      // all ones, 3*5*17*257 with 65537 left over
      '{32'hFFFF_FFFF,  1'b0, '0},
      '{32'hAAAA_AAAA,  1'b0, '0},
      '{32'h5555_5555,  1'b0, '0},
      '{32'hFFFF_0000,  1'b0, '0},
      // largest 32-bit prime, divisor runs up to 65537 and needs all 17 bits
      '{32'd4294967291, 1'b1, tdpp_rsp_type'{32'd4294967291, 1'b1, 1'b0, 1'b1}}
   };

   // append one result to the expected stream
   function automatic void add_expected(tdpp_rsp_type r);
      expected_powers = {expected_powers, r};
   endfunction

   // trial division by 2, 3, 5, 7, 9, ... queueing d, d^2, ..., d^k per prime and any leftover
   function automatic void predict_prime_powers(logic [IN_BITS-1:0] value);
      longint unsigned rest;
      longint unsigned divisor;
      longint unsigned power;
      tdpp_rsp_type    r;
      rest    = value;
      divisor = 2;
      if (rest <= 1) begin
         r = '{rest[FP_BITS-1:0], 1'b0, 1'b1, 1'b1};
         add_expected(r);
         return;
      end
      while (divisor * divisor <= rest) begin
         power = divisor;
         while (rest % divisor == 0) begin
            r = '{power[FP_BITS-1:0], 1'b0, 1'b0, 1'b0};
            add_expected(r);
            power = power * divisor;
            rest  = rest / divisor;
         end
         divisor = (divisor == 2) ? 3 : divisor + 2;
      end
      // whatever survives above one is a prime beyond the square root
      if (rest > 1) begin
         r = '{rest[FP_BITS-1:0], 1'b1, 1'b0, 1'b0};
         add_expected(r);
      end
      expected_powers[expected_powers.size() - 1].last = 1'b1;
   endfunction

   // random value that factors quickly: small primes times a bounded cofactor
   function automatic logic [IN_BITS-1:0] pick_factorable_value();
      int unsigned     kind;
      int unsigned     prime;
      longint unsigned product;
      kind = $urandom_range(0, 99);
      if (kind < 3)
         return $urandom_range(0, 1);
      if (kind < 10)
         return $urandom_range(2, 65535);
      // a few deep ones with a cofactor up to 2^22, the rest below 2^16
      if (kind < 15)
         product = $urandom_range(1, 1 << 22);
      else
         product = $urandom_range(1, 65535);
      prime = small_primes[$urandom_range(0, NUM_SMALL_PRIMES - 1)];
      repeat ($urandom_range(0, 28)) begin
         // half the time reuse the previous prime to build high powers
         if ($urandom_range(0, 1) == 0)
            prime = small_primes[$urandom_range(0, NUM_SMALL_PRIMES - 1)];
         if (product * prime <= 64'hFFFF_FFFF)
            product = product * prime;
      end
      return product[IN_BITS-1:0];
   endfunction

   // offer one value and hold it until the block takes it
   task automatic offer_value(input factor_case_type fc);
      offered_values = {offered_values, fc};
      req_bus.valid      <= 1'b1;
      req_bus.data.value <= fc.value;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering until every predicted result has been seen
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_powers.size() != 0) @(posedge clock);
   endtask

   // sender: reset, directed table, random part, then wrap up
   initial begin
      factor_case_type fc;
      bit              calm;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         offer_value(directed_cases[i]);
         if ($urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 17));
      end

      calm = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // idle-free stretches come and go every 16 items
         if (i % 16 == 0)
            calm = ($urandom_range(0, 2) == 0);
         // tail end runs flat out on both sides
         if (i == RANDOM_ITEMS - CALM_TAIL)
            rsp_quiet <= 1'b1;
         // receiver backs off for a long time while values keep coming
         if (i == 30)
            long_hold_ask <= 1'b1;
         // once, let everything in flight come out before going on
         if (i == 60)
            wait_results_drained();

         fc = '{pick_factorable_value(), 1'b0, '0};
         offer_value(fc);
         if (i < RANDOM_ITEMS - CALM_TAIL && !calm && $urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 17));
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // receiver: random stall bursts plus one long hold-off on request
   int  rx_hold_left   = 0;
   bit  long_hold_done = 1'b0;

   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left  = rx_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_ask && !long_hold_done) begin
         long_hold_done = 1'b1;
         rx_hold_left   = LONG_HOLD_CYCLES - 1;
         rsp_bus.ready  <= 1'b0;
      end else if (!rsp_quiet && $urandom_range(0, 9) == 0) begin
         rx_hold_left  = $urandom_range(1, 17) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      factor_case_type fc;
      tdpp_rsp_type    want;
      tdpp_rsp_type    got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            fc = offered_values.pop_front();
            if (fc.pinned)
               add_expected(fc.pinned_rsp);
            else
               predict_prime_powers(req_bus.data.value);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (expected_powers.size() == 0) begin
               $error("result transfer with nothing expected: factor_power %0d",
                      got.factor_power);
               error_count++;
            end else begin
               want = expected_powers.pop_front();
               if (got.factor_power !== want.factor_power) begin
                  $error("factor_power: expected %0d, actual %0d",
                         want.factor_power, got.factor_power);
                  error_count++;
               end
               if (got.is_leftover !== want.is_leftover) begin
                  $error("is_leftover: expected %0b, actual %0b",
                         want.is_leftover, got.is_leftover);
                  error_count++;
               end
               if (got.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, actual %0b",
                         want.empty_res, got.empty_res);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

FILE: trial_division_prime_powers.f
design/tdpp_pkg.sv
design/tdpp_stream_if.sv
design/trial_division_prime_powers.sv
test/tb.sv
